// ===== rtl/fhcg_pkg.sv =====
// package: widths, crc constants and header crc helpers for the frame header crc generator
`timescale 1ns / 1ps

package fhcg_pkg;

	localparam int MAX_PAYLOAD = 16384;
	localparam int MAX_W = 16;
	localparam int COUNT_W = 15;
	localparam int COUNT_TOP = (1 << COUNT_W) - 1;
	localparam int CAP_I = (MAX_PAYLOAD + 1 > COUNT_TOP) ? COUNT_TOP : MAX_PAYLOAD + 1;
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_I);
	localparam logic [MAX_W-1:0] MAX_LEN = MAX_W'(MAX_PAYLOAD);

	localparam int OPCODE_W = 16;
	localparam int SEQ_W = 32;
	localparam int BYTE_W = 8;
	localparam int CRC_W = 32;
	localparam int HDR_BITS = OPCODE_W + SEQ_W;

	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 96;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	typedef logic [CRC_W-1:0] hdr_cols_t [HDR_BITS];

	// one reflected crc bit step
	function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] c, input logic b);
		logic fb;
		fb = c[0] ^ b;
		return {1'b0, c[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
	endfunction

	// crc of an all-zero header starting from all ones
	function automatic logic [CRC_W-1:0] gen_hdr_init();
		logic [CRC_W-1:0] c;
		c = CRC_INIT;
		for (int k = 0; k < HDR_BITS; k++) begin
			c = crc_bit(c, 1'b0);
		end
		return c;
	endfunction

	// contribution of each single header bit from a zero register
	function automatic hdr_cols_t gen_hdr_cols();
		hdr_cols_t cols;
		logic [CRC_W-1:0] c;
		for (int i = 0; i < HDR_BITS; i++) begin
			c = '0;
			for (int k = 0; k < HDR_BITS; k++) begin
				c = crc_bit(c, k == i);
			end
			cols[i] = c;
		end
		return cols;
	endfunction

	localparam logic [CRC_W-1:0] HDR_INIT = gen_hdr_init();
	localparam hdr_cols_t HDR_COLS = gen_hdr_cols();

	// header crc is linear in its bits: one flat xor per crc bit
	function automatic logic [CRC_W-1:0] hdr_crc(input logic [HDR_BITS-1:0] h);
		logic [CRC_W-1:0] acc;
		acc = HDR_INIT;
		for (int i = 0; i < HDR_BITS; i++) begin
			if (h[i]) begin
				acc = acc ^ HDR_COLS[i];
			end
		end
		return acc;
	endfunction

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
			input logic [BYTE_W-1:0] d);
		logic [CRC_W-1:0] r;
		r = c;
		for (int i = 0; i < BYTE_W; i++) begin
			r = crc_bit(r, d[i]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/frame_header_crc_generator.sv =====
// top level: frame header crc generator, at most one payload byte per request
`timescale 1ns / 1ps

// channel  | ports                          | contents
// ---------+--------------------------------+------------------------------------------
// in       | s_axis_tvalid/tready/tdata/... | at most one byte per request, tlast ends frame
// out      | m_axis_tvalid/tready/tdata/... | one header per frame, tuser = accepted
//
// one request a cycle is taken unless a closing request waits on a stalled
// result; each goes through an input register and one pass of logic into the
// frame state and the result register. the header crc is formed while the
// request enters the input register. reset clears all valid flags and returns
// the crc state to all ones; a stalled result holds only a closing request,
// which waits in the input register and so holds the requests behind it.

module frame_header_crc_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// opcode[15:0], seq_number[47:16], data_byte[55:48]
	input  logic [fhcg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// byte_valid[0]
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// frame_length[14:0], frame_opcode[30:15], frame_seq[62:31], checksum[94:63], zero pad
	output logic [fhcg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// accepted[0]
	output logic                              m_axis_tuser
);

	// input register
	logic                            v_s1;
	logic [fhcg_pkg::OPCODE_W-1:0]   opcode_s1;
	logic [fhcg_pkg::SEQ_W-1:0]      seq_s1;
	logic [fhcg_pkg::BYTE_W-1:0]     byte_s1;
	logic                            byte_valid_s1;
	logic                            last_s1;
	logic [fhcg_pkg::CRC_W-1:0]      hdr_crc_s1;

	// frame state
	logic                            in_frame_q;
	logic [fhcg_pkg::CRC_W-1:0]      crc_q;
	logic [fhcg_pkg::COUNT_W-1:0]    count_q;
	logic [fhcg_pkg::OPCODE_W-1:0]   held_opcode_q;
	logic [fhcg_pkg::SEQ_W-1:0]      held_seq_q;

	// result register
	logic                            out_valid_q;
	logic [fhcg_pkg::COUNT_W-1:0]    out_length_q;
	logic [fhcg_pkg::OPCODE_W-1:0]   out_opcode_q;
	logic [fhcg_pkg::SEQ_W-1:0]      out_seq_q;
	logic [fhcg_pkg::CRC_W-1:0]      out_crc_q;
	logic                            out_acc_q;

	logic                            out_free;
	logic                            fire;
	logic [fhcg_pkg::CRC_W-1:0]      base_crc;
	logic [fhcg_pkg::COUNT_W-1:0]    base_count;
	logic [fhcg_pkg::OPCODE_W-1:0]   cur_opcode;
	logic [fhcg_pkg::SEQ_W-1:0]      cur_seq;
	logic [fhcg_pkg::CRC_W-1:0]      next_crc;
	logic [fhcg_pkg::COUNT_W-1:0]    next_count;
	logic                            ok;

	assign out_free = !out_valid_q || m_axis_tready;
	// a request that closes no frame never waits on the output side
	assign fire = v_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !v_s1 || fire;

	always_comb begin
		base_crc   = in_frame_q ? crc_q : hdr_crc_s1;
		base_count = in_frame_q ? count_q : '0;
		cur_opcode = in_frame_q ? held_opcode_q : opcode_s1;
		cur_seq    = in_frame_q ? held_seq_q : seq_s1;
		next_crc   = byte_valid_s1 ? fhcg_pkg::crc_byte(base_crc, byte_s1) : base_crc;
		next_count = (byte_valid_s1 && (base_count < fhcg_pkg::COUNT_CAP)) ?
			base_count + 1'b1 : base_count;
		ok = {1'b0, next_count} <= fhcg_pkg::MAX_LEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1     <= s_axis_tdata[15:0];
			seq_s1        <= s_axis_tdata[47:16];
			byte_s1       <= s_axis_tdata[55:48];
			byte_valid_s1 <= s_axis_tuser;
			last_s1       <= s_axis_tlast;
			hdr_crc_s1    <= fhcg_pkg::hdr_crc(s_axis_tdata[47:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			crc_q         <= fhcg_pkg::CRC_INIT;
			count_q       <= '0;
			held_opcode_q <= '0;
			held_seq_q    <= '0;
		end else if (fire) begin
			held_opcode_q <= cur_opcode;
			held_seq_q    <= cur_seq;
			if (last_s1) begin
				in_frame_q <= 1'b0;
				crc_q      <= fhcg_pkg::CRC_INIT;
				count_q    <= '0;
			end else begin
				in_frame_q <= 1'b1;
				crc_q      <= next_crc;
				count_q    <= next_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			out_length_q <= ok ? next_count : '0;
			out_opcode_q <= ok ? cur_opcode : '0;
			out_seq_q    <= ok ? cur_seq : '0;
			out_crc_q    <= ok ? ~next_crc : '0;
			out_acc_q    <= ok;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_crc_q, out_seq_q, out_opcode_q, out_length_q};
	assign m_axis_tuser  = out_acc_q;

	// count is held at zero and crc at all ones outside a frame
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (count_q == '0 && crc_q == fhcg_pkg::CRC_INIT))
		else $error("frame state not cleared outside a frame");

	// saturation bound on the running count
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fhcg_pkg::COUNT_CAP)
		else $error("byte count beyond its cap");

	// a closing request loads a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> m_axis_tvalid)
		else $error("closing request gave no result");

	// rejected headers carry zero fields
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("rejected header with non-zero fields");

	// accepted headers stay within the payload limit
	a_accept_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> ({1'b0, out_length_q} <= fhcg_pkg::MAX_LEN))
		else $error("accepted header longer than the limit");

endmodule

// ===== tb/frame_header_crc_generator_test.sv =====
// testbench: frame header crc generator, directed table and random traffic
`timescale 1ns / 1ps

module frame_header_crc_generator_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1550;
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_TOGGLE
	} sink_mode_t;

	typedef struct {
		logic [15:0] opcode;
		logic [31:0] seq;
		logic [7:0]  data;
		logic        byte_valid;
		logic        is_last;
	} payload_req_t;

	typedef struct {
		logic [14:0] len;
		logic [15:0] opcode;
		logic [31:0] seq;
		logic [31:0] crc;
		logic        accepted;
	} header_t;

	// request fields, then whether the header is typed in, then the typed header
	typedef struct {
		logic [15:0] opcode;
		logic [31:0] seq;
		logic [7:0]  data;
		logic        byte_valid;
		logic        is_last;
		bit          typed;
		logic [14:0] len;
		logic [15:0] hdr_opcode;
		logic [31:0] hdr_seq;
		logic        accepted;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// opcode[15:0], seq_number[47:16], data_byte[55:48]
	logic [fhcg_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	// byte_valid[0]
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// frame_length[14:0], frame_opcode[30:15], frame_seq[62:31], checksum[94:63], zero pad
	logic [fhcg_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	// accepted[0]
	logic m_axis_tuser;

	// header model state
	logic [31:0] crc_acc;
	logic [14:0] len_acc;
	bit          frame_open;
	logic [15:0] held_opcode;
	logic [31:0] held_seq;

	header_t expected_headers [$];

	int mismatches = 0;
	int headers_seen = 0;
	int items_sent = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int rejected_frames = 0;
	int stall_cycles = 0;
	int burst_left = 0;
	int sink_cyc = 0;
	int hold_left = 0;
	int holds_done = 0;

	dir_row_t directed_rows [14] = '{
		// empty frame straight after reset
		'{16'h0000, 32'h0000_0000, 8'h00, 1'b0, 1'b1, 1'b1, 15'd0, 16'h0000, 32'h0000_0000, 1'b1},
		'{16'hffff, 32'hffff_ffff, 8'hff, 1'b0, 1'b1, 1'b1, 15'd0, 16'hffff, 32'hffff_ffff, 1'b1},
		// frame opened by a request with no byte
		'{16'h1234, 32'h89ab_cdef, 8'h5a, 1'b0, 1'b0, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0},
		'{16'h0000, 32'h0000_0000, 8'h00, 1'b1, 1'b0, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0},
		'{16'hffff, 32'hffff_ffff, 8'hff, 1'b1, 1'b1, 1'b1, 15'd2, 16'h1234, 32'h89ab_cdef, 1'b1},
		// single byte carrying last
		'{16'ha5a5, 32'h5a5a_5a5a, 8'h80, 1'b1, 1'b1, 1'b1, 15'd1, 16'ha5a5, 32'h5a5a_5a5a, 1'b1},
		// opcode and sequence changing mid frame are ignored
		'{16'h0001, 32'h0000_0001, 8'h01, 1'b1, 1'b0, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0},
		'{16'hffff, 32'hffff_ffff, 8'h7f, 1'b0, 1'b0, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0},
		'{16'h8000, 32'h8000_0000, 8'hfe, 1'b1, 1'b1, 1'b1, 15'd2, 16'h0001, 32'h0000_0001, 1'b1},
		// last without a byte after payload
		'{16'h00ff, 32'h0000_ffff, 8'h55, 1'b1, 1'b0, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0},
		'{16'hff00, 32'hffff_0000, 8'haa, 1'b0, 1'b1, 1'b1, 15'd1, 16'h00ff, 32'h0000_ffff, 1'b1},
		'{16'h5555, 32'haaaa_5555, 8'h01, 1'b1, 1'b0, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0},
		'{16'haaaa, 32'h5555_aaaa, 8'h02, 1'b1, 1'b0, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0},
		'{16'h3c3c, 32'hc3c3_3c3c, 8'h03, 1'b1, 1'b1, 1'b0, 15'd0, 16'h0000, 32'h0000_0000, 1'b0}
	};

	frame_header_crc_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// reflected crc-32, one byte lsb first
	function automatic logic [31:0] crc32_feed(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ fhcg_pkg::CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// advances the header model by one request; returns 1 when a header is due
	function automatic bit header_step(input payload_req_t r, output header_t h);
		logic [14:0] cap;
		cap = (fhcg_pkg::MAX_PAYLOAD + 1 > 32767) ? 15'h7fff : 15'(fhcg_pkg::MAX_PAYLOAD + 1);
		h = '{default: '0};
		if (!frame_open) begin
			held_opcode = r.opcode;
			held_seq = r.seq;
			crc_acc = fhcg_pkg::CRC_INIT;
			crc_acc = crc32_feed(crc_acc, r.opcode[7:0]);
			crc_acc = crc32_feed(crc_acc, r.opcode[15:8]);
			crc_acc = crc32_feed(crc_acc, r.seq[7:0]);
			crc_acc = crc32_feed(crc_acc, r.seq[15:8]);
			crc_acc = crc32_feed(crc_acc, r.seq[23:16]);
			crc_acc = crc32_feed(crc_acc, r.seq[31:24]);
			len_acc = '0;
			frame_open = 1'b1;
		end
		if (r.byte_valid) begin
			crc_acc = crc32_feed(crc_acc, r.data);
			if (len_acc < cap) begin
				len_acc = len_acc + 15'd1;
			end
		end
		if (!r.is_last) begin
			return 1'b0;
		end
		if (len_acc <= fhcg_pkg::MAX_PAYLOAD) begin
			h.len = len_acc;
			h.opcode = held_opcode;
			h.seq = held_seq;
			h.crc = ~crc_acc;
			h.accepted = 1'b1;
		end else begin
			rejected_frames++;
		end
		frames_sent++;
		crc_acc = fhcg_pkg::CRC_INIT;
		len_acc = '0;
		frame_open = 1'b0;
		return 1'b1;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("header %0d: %s expected %h, got %h", headers_seen, what, want, got);
			end
		end
	endfunction

	// offers one request in the current burst and waits for it to be taken
	task automatic send_req(input payload_req_t r, input bit typed, input header_t typed_hdr);
		header_t h;
		header_t want;
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= {r.data, r.seq, r.opcode};
		s_axis_tuser <= r.byte_valid;
		s_axis_tlast <= r.is_last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (r.byte_valid) begin
			bytes_sent++;
		end
		if (header_step(r, h)) begin
			want = h;
			if (typed) begin
				want = typed_hdr;
				want.crc = typed_hdr.accepted ? h.crc : 32'd0;
			end
			expected_headers.insert(expected_headers.size(), want);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_headers.size() != 0);
	endtask

	task automatic random_frame();
		payload_req_t r;
		header_t none;
		int n_bytes;
		int sent;
		int pick;
		bit tail_empty;
		bit done;
		none = '{default: '0};
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			n_bytes = $urandom_range(0, 8);
		end else if (pick < 95) begin
			n_bytes = $urandom_range(9, 40);
		end else begin
			n_bytes = $urandom_range(41, 120);
		end
		tail_empty = (n_bytes == 0) || ($urandom_range(0, 3) == 0);
		sent = 0;
		done = 1'b0;
		while (!done) begin
			case ($urandom_range(0, 7))
				0: r.opcode = 16'h0000;
				1: r.opcode = 16'hffff;
				default: r.opcode = 16'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: r.seq = 32'h0000_0000;
				1: r.seq = 32'hffff_ffff;
				default: r.seq = $urandom;
			endcase
			r.data = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0) begin
				// byte-less filler inside the frame
				r.byte_valid = 1'b0;
				r.is_last = 1'b0;
			end else if (sent < n_bytes) begin
				r.byte_valid = 1'b1;
				r.is_last = (sent == n_bytes - 1) && !tail_empty;
				sent++;
				done = r.is_last;
			end else begin
				r.byte_valid = 1'b0;
				r.is_last = 1'b1;
				done = 1'b1;
			end
			send_req(r, 1'b0, none);
		end
	endtask

	// result checker, receiver stall pattern and idle counter
	always @(posedge clk) begin : sink
		header_t want;
		bit moved;
		if (arst_n) begin
			moved = s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				headers_seen++;
				if (expected_headers.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("header %0d arrived with none outstanding: %h", headers_seen,
							m_axis_tdata);
					end
				end else begin
					want = expected_headers.pop_front();
					check_field("frame_length", 32'(want.len), 32'(m_axis_tdata[14:0]));
					check_field("frame_opcode", 32'(want.opcode), 32'(m_axis_tdata[30:15]));
					check_field("frame_seq", want.seq, m_axis_tdata[62:31]);
					check_field("checksum", want.crc, m_axis_tdata[94:63]);
					check_field("accepted", 32'(want.accepted), 32'(m_axis_tuser));
					check_field("pad", 32'd0, 32'(m_axis_tdata[95]));
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			sink_cyc++;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (holds_done < 2 && headers_seen >= 40 + 100 * holds_done) begin
				// long hold-off so the block backs up and stalls its input
				holds_done++;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				case (sink_mode_t'((sink_cyc >> 7) % 4))
					SINK_OPEN: m_axis_tready <= 1'b1;
					SINK_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					SINK_TOGGLE: m_axis_tready <= 1'(sink_cyc % 2);
				endcase
			end
		end
	end

	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		payload_req_t r;
		header_t th;
		int random_start;
		crc_acc = fhcg_pkg::CRC_INIT;
		len_acc = '0;
		frame_open = 1'b0;
		held_opcode = '0;
		held_seq = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			r.opcode = directed_rows[i].opcode;
			r.seq = directed_rows[i].seq;
			r.data = directed_rows[i].data;
			r.byte_valid = directed_rows[i].byte_valid;
			r.is_last = directed_rows[i].is_last;
			th.len = directed_rows[i].len;
			th.opcode = directed_rows[i].hdr_opcode;
			th.seq = directed_rows[i].hdr_seq;
			th.crc = '0;
			th.accepted = directed_rows[i].accepted;
			send_req(r, directed_rows[i].typed, th);
		end
		wait_drained();

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			random_frame();
			if ($urandom_range(0, 39) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("run covered %0d requests in %0d frames, %0d payload bytes, %0d headers checked",
			items_sent, frames_sent, bytes_sent, headers_seen);
		$display("overlong frames rejected: %0d, mismatches: %0d", rejected_frames, mismatches);
		if (mismatches == 0 && expected_headers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fhcg_pkg.sv
rtl/frame_header_crc_generator.sv
tb/frame_header_crc_generator_test.sv
